FILE: sv/completion_tag_tracker_assert.svh
// ----------------------------------------------------------------------------
// completion_tag_tracker assertion macros
// Wrappers for the tracker's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef COMPLETION_TAG_TRACKER_ASSERT_SVH
`define COMPLETION_TAG_TRACKER_ASSERT_SVH

// checked outside reset
`define CTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define CTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and codes of the completion tag tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctt_pkg;

  localparam logic [2:0] ACT_BEGIN  = 3'd0;
  localparam logic [2:0] ACT_FINISH = 3'd1;
  localparam logic [2:0] ACT_CANCEL = 3'd2;
  localparam logic [2:0] ACT_POLL   = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [2:0] ST_FREE      = 3'd0;
  localparam logic [2:0] ST_PENDING   = 3'd1;
  localparam logic [2:0] ST_DONE      = 3'd2;
  localparam logic [2:0] ST_CANCELED  = 3'd3;
  localparam logic [2:0] ST_TIMED_OUT = 3'd4;

  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] generation;
    logic [31:0] deadline;
    logic        timed;
    logic [31:0] status;
    logic [31:0] transferred;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  localparam slot_t SLOT_RESET = '{state: ST_FREE, generation: 32'd1, deadline: 32'd0,
                                   timed: 1'b0, status: 32'd0, transferred: 32'd0};

  typedef struct packed {
    logic        is_free;
    logic        is_pending;
    logic        is_closed;
    logic        id_match;
    logic        expired;
    logic [31:0] gen_inc;
  } eval_t;

endpackage

FILE: sv/completion_tag_tracker.sv
// ----------------------------------------------------------------------------
// completion_tag_tracker
// Generation-tagged request slot table with begin/finish/cancel/poll/tick.
// ----------------------------------------------------------------------------
// One command at a time; busy is high while a command runs. Slots sit in one
// RAM and a single check unit visits them one at a time (read, check).
// Finish and cancel check one slot; a bad id or unknown action ends without
// a slot visit; begin probes from the hint until a free slot is found or all
// SLOTS are probed; tick checks all slots; a poll retiring a request then
// scans for a closed request. The result word holds until the next command is
// accepted and cannot be held off. event_pending is valid at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module completion_tag_tracker #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               timeout_we,
  input  logic signed [31:0] timeout_code,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [31:0]        deadline,
  input  logic               timed,
  input  logic [31:0]        req_generation,
  input  logic [15:0]        req_slot,
  input  logic signed [31:0] status_in,
  input  logic [31:0]        transferred_in,
  input  logic [31:0]        now_time,
  output logic               done,
  output logic               ok,
  output logic [31:0]        out_generation,
  output logic [15:0]        out_slot,
  output logic signed [31:0] res_status,
  output logic [31:0]        res_transferred,
  output logic [2:0]         res_state,
  output logic               event_pending
);
  import ctt_pkg::*;

  localparam int          IDXW   = $clog2(SLOTS);
  localparam logic [16:0] SLOTS_W = 17'(SLOTS);
  localparam logic [IDXW-1:0] LAST = IDXW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_ERD  = 3'd3;
  localparam logic [2:0] S_ECHK = 3'd4;

  logic [2:0]        state;
  logic [2:0]        op;
  logic [IDXW-1:0]   k;
  logic [IDXW-1:0]   cnt;
  logic [IDXW-1:0]   hint;
  logic              event_bit;
  logic [SLOTS-1:0]  vld;
  logic              rd_vld;
  logic [31:0]       tmo_status;
  logic [31:0]       deadline_q;
  logic              timed_q;
  logic [31:0]       gen_q;
  logic [31:0]       status_q;
  logic [31:0]       xfer_q;
  logic [31:0]       now_q;

  logic [SLOT_W-1:0] ram_q;
  slot_t             ent;
  eval_t             ev;
  logic              wr_en;
  slot_t             wr_data;
  logic              id_ok;
  logic [IDXW-1:0]   k_wrap;
  logic              done_next;

  assign ent   = rd_vld ? slot_t'(ram_q) : SLOT_RESET;
  assign busy  = (state != S_IDLE);
  assign event_pending = event_bit;
  assign id_ok = (req_slot != 16'd0) && ({1'b0, req_slot} <= SLOTS_W)
                 && (req_generation != 32'd0);
  assign k_wrap = (k == LAST) ? '0 : k + 1'b1;

  ctt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (k),
    .wdata (wr_data),
    .raddr (k),
    .rdata (ram_q)
  );

  ctt_eval u_eval (
    .ent            (ent),
    .req_generation (gen_q),
    .now_time       (now_q),
    .ev             (ev)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_data = ent;
    if (state == S_CHK) begin
      unique case (op) inside
        ACT_BEGIN: begin
          if (ev.is_free) begin
            wr_en               = 1'b1;
            wr_data.state       = ST_PENDING;
            wr_data.deadline    = deadline_q;
            wr_data.timed       = timed_q;
            wr_data.status      = '0;
            wr_data.transferred = '0;
          end
        end
        ACT_FINISH, ACT_CANCEL: begin
          if (ev.id_match && ev.is_pending) begin
            wr_en               = 1'b1;
            wr_data.deadline    = '0;
            wr_data.timed       = 1'b0;
            if (op == ACT_FINISH) begin
              wr_data.state       = ST_DONE;
              wr_data.status      = status_q;
              wr_data.transferred = xfer_q;
            end else begin
              wr_data.state       = ST_CANCELED;
              wr_data.status      = '1;
              wr_data.transferred = '0;
            end
          end
        end
        ACT_POLL: begin
          if (ev.id_match && !ev.is_pending) begin
            wr_en               = 1'b1;
            wr_data.state       = ST_FREE;
            wr_data.generation  = ev.gen_inc;
            wr_data.deadline    = '0;
            wr_data.timed       = 1'b0;
            wr_data.status      = '0;
            wr_data.transferred = '0;
          end
        end
        ACT_TICK: begin
          if (ev.expired) begin
            wr_en               = 1'b1;
            wr_data.state       = ST_TIMED_OUT;
            wr_data.deadline    = '0;
            wr_data.timed       = 1'b0;
            wr_data.status      = tmo_status;
            wr_data.transferred = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    done_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (action) inside
            ACT_BEGIN, ACT_TICK:              done_next = 1'b0;
            ACT_FINISH, ACT_CANCEL, ACT_POLL: done_next = !id_ok;
            default:                          done_next = 1'b1;
          endcase
        end
      end
      S_CHK: begin
        unique case (op) inside
          ACT_BEGIN:              done_next = ev.is_free || (cnt == LAST);
          ACT_FINISH, ACT_CANCEL: done_next = 1'b1;
          ACT_POLL:               done_next = !(ev.id_match && !ev.is_pending);
          ACT_TICK:               done_next = (cnt == LAST);
          default:                done_next = 1'b1;
        endcase
      end
      S_ECHK:  done_next = ev.is_closed || (cnt == LAST);
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      hint       <= '0;
      event_bit  <= 1'b0;
      vld        <= '0;
      rd_vld     <= 1'b0;
      tmo_status <= '1;
    end else begin
      if (timeout_we) begin
        tmo_status <= timeout_code;
      end
      done   <= done_next;
      rd_vld <= vld[k];
      if (wr_en) begin
        vld[k] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op              <= action;
            deadline_q      <= deadline;
            timed_q         <= timed;
            gen_q           <= req_generation;
            status_q        <= status_in;
            xfer_q          <= transferred_in;
            now_q           <= now_time;
            cnt             <= '0;
            ok              <= 1'b0;
            out_generation  <= '0;
            out_slot        <= '0;
            res_status      <= '0;
            res_transferred <= '0;
            res_state       <= ST_FREE;
            unique case (action) inside
              ACT_BEGIN: begin
                k     <= hint;
                state <= S_RD;
              end
              ACT_FINISH, ACT_CANCEL, ACT_POLL: begin
                if (id_ok) begin
                  k     <= IDXW'(req_slot - 16'd1);
                  state <= S_RD;
                end
              end
              ACT_TICK: begin
                k     <= '0;
                state <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          unique case (op) inside
            ACT_BEGIN: begin
              if (ev.is_free) begin
                ok             <= 1'b1;
                out_generation <= ent.generation;
                out_slot       <= 16'(k) + 16'd1;
                hint           <= k_wrap;
                state          <= S_IDLE;
              end else if (cnt == LAST) begin
                state <= S_IDLE;
              end else begin
                cnt   <= cnt + 1'b1;
                k     <= k_wrap;
                state <= S_RD;
              end
            end
            ACT_FINISH, ACT_CANCEL: begin
              if (ev.id_match && ev.is_pending) begin
                ok        <= 1'b1;
                event_bit <= 1'b1;
              end
              state <= S_IDLE;
            end
            ACT_POLL: begin
              if (ev.id_match && !ev.is_pending) begin
                ok              <= 1'b1;
                res_status      <= ent.status;
                res_transferred <= ent.transferred;
                res_state       <= ent.state;
                if (hint > k) begin
                  hint <= k;
                end
                event_bit <= 1'b0;
                k         <= '0;
                cnt       <= '0;
                state     <= S_ERD;
              end else begin
                state <= S_IDLE;
              end
            end
            ACT_TICK: begin
              if (ev.expired) begin
                event_bit <= 1'b1;
              end
              if (cnt == LAST) begin
                ok    <= 1'b1;
                state <= S_IDLE;
              end else begin
                cnt   <= cnt + 1'b1;
                k     <= k + 1'b1;
                state <= S_RD;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_ERD: state <= S_ECHK;
        S_ECHK: begin
          if (ev.is_closed) begin
            event_bit <= 1'b1;
            state     <= S_IDLE;
          end else if (cnt == LAST) begin
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 1'b1;
            k     <= k + 1'b1;
            state <= S_ERD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "completion_tag_tracker_assert.svh"

  `CTT_ASSERT(a_tick_busy, (start && !busy && action == ACT_TICK) |=> busy,
              "tick not started")
  `CTT_ASSERT(a_fail_zero_id,
              (done && !ok) |-> (out_slot == 16'd0 && out_generation == 32'd0),
              "failed word carries an id")
  `CTT_ASSERT(a_res_state,
              (done && res_state != ST_FREE) |-> (ok && (res_state == ST_DONE ||
                res_state == ST_CANCELED || res_state == ST_TIMED_OUT)),
              "bad retired state")
  `CTT_ASSERT_RST(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")

endmodule

FILE: sv/ctt_ram.sv
// ----------------------------------------------------------------------------
// ctt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ctt_eval.sv
// ----------------------------------------------------------------------------
// ctt_eval
// Per-entry check unit: state decode, id match, wrap-safe deadline compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctt_eval (
  input  ctt_pkg::slot_t ent,
  input  logic [31:0]    req_generation,
  input  logic [31:0]    now_time,
  output ctt_pkg::eval_t ev
);
  import ctt_pkg::*;

  logic [31:0] diff;
  logic [31:0] gen_p1;

  assign diff   = now_time - ent.deadline;
  assign gen_p1 = ent.generation + 32'd1;

  always_comb begin
    ev.is_free    = (ent.state == ST_FREE);
    ev.is_pending = (ent.state == ST_PENDING);
    ev.is_closed  = (ent.state != ST_FREE) && (ent.state != ST_PENDING);
    ev.id_match   = (ent.state != ST_FREE) && (ent.generation == req_generation);
    ev.expired    = ev.is_pending && ent.timed && !diff[31];
    ev.gen_inc    = (gen_p1 == 32'd0) ? 32'd1 : gen_p1;
  end

endmodule
